### src/cmta_pkg.sv
// shared types and constants of the collision mesh tally accumulator
// no dependencies

package cmta_pkg;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SEARCH,
    S_CSETUP,
    S_DIV,
    S_CEND,
    S_XCHK,
    S_MUL2,
    S_SCORE,
    S_UPD,
    S_DONE
  } state_t;

  localparam logic [2:0] REG_LOW_X  = 3'd0;
  localparam logic [2:0] REG_LOW_Y  = 3'd1;
  localparam logic [2:0] REG_LOW_Z  = 3'd2;
  localparam logic [2:0] REG_PITCH_X = 3'd3;
  localparam logic [2:0] REG_PITCH_Y = 3'd4;
  localparam logic [2:0] REG_PITCH_Z = 3'd5;
  localparam logic [2:0] REG_NORM   = 3'd6;
  localparam logic [2:0] REG_MODE   = 3'd7;

  localparam logic [1:0] MODE_WEIGHT  = 2'd0;
  localparam logic [1:0] MODE_PARTIAL = 2'd1;
  localparam logic [1:0] MODE_TOTAL   = 2'd2;
  localparam logic [1:0] MODE_IMAG    = 2'd3;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic signed [39:0] SCORE_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] SCORE_MIN = 40'sh80_0000_0000;
  localparam logic signed [47:0] BIN_MAX   = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] BIN_MIN   = 48'sh8000_0000_0000;

  localparam logic [41:0] QUOT_CAP = 42'h200_0000_0000;

endpackage

### src/collision_mesh_tally_accumulator.sv
// collision mesh tally accumulator: mesh cell and energy bin lookup, score
// division on one shared restoring divider, saturating tally memory
// depends on cmta_pkg
//
// items enter on item_valid/item_stall, one result per item leaves on
// result_valid/result_stall from an output register; configuration is a
// plain write port (cfg_write, cfg_index, cfg_data) that the user must use
// only while idle; the block does not enforce this. after reset the tally
// memory is swept to zero, one entry a cycle, over all TALLY entries
// (ENERGY_BINS*MESH_X*MESH_Y*MESH_Z, 65536 by default); the block holds
// item_stall high during that sweep. one item is handled at a time: a
// bound load goes straight to its result; a scoring item takes a bin
// search over up to ENERGY_BINS bins, per axis a division on the shared
// divider (32 quotient bits each), the multiply steps S_XCHK and S_MUL2,
// a division of 80 quotient bits for the score, then S_SCORE and the
// memory update in S_UPD; items skipped early finish sooner. the next
// item can be taken in the cycle in which the previous result first appears.
// while the receiver stalls, the result holds in the output register; one
// more item is taken and worked on, then waits in its finish step until
// that register frees up, and no further item is taken meanwhile.

module collision_mesh_tally_accumulator #(
  parameter int MESH_X = 16,
  parameter int MESH_Y = 16,
  parameter int MESH_Z = 16,
  parameter int ENERGY_BINS = 16,
  localparam int SLOT_W = $clog2(ENERGY_BINS + 1),
  localparam longint TALLY = longint'(ENERGY_BINS) * MESH_X * MESH_Y * MESH_Z,
  localparam int ADDR_W = (TALLY > 1) ? $clog2(TALLY) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [2:0]               cfg_index,
  input  logic [31:0]              cfg_data,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic                     cmd,
  input  logic signed [31:0]       pos_x,
  input  logic signed [31:0]       pos_y,
  input  logic signed [31:0]       pos_z,
  input  logic [31:0]              energy,
  input  logic signed [31:0]       weight,
  input  logic signed [31:0]       weight_imag,
  input  logic [31:0]              xs_total,
  input  logic [31:0]              xs_partial,
  input  logic [SLOT_W-1:0]        bound_index,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic                     scored,
  output logic [ADDR_W-1:0]        bin_address,
  output logic signed [39:0]       added_score,
  output logic signed [47:0]       bin_total
);

  localparam int NB = ENERGY_BINS + 1;
  localparam int XW = (MESH_X > 1) ? $clog2(MESH_X) : 1;
  localparam int YW = (MESH_Y > 1) ? $clog2(MESH_Y) : 1;
  localparam int ZW = (MESH_Z > 1) ? $clog2(MESH_Z) : 1;
  localparam longint STRIDE_E = longint'(MESH_X) * MESH_Y * MESH_Z;
  localparam longint STRIDE_X = longint'(MESH_Y) * MESH_Z;

  cmta_pkg::state_t state, state_next;

  logic signed [31:0] low_x, low_y, low_z;
  logic [30:0] pitch_x, pitch_y, pitch_z;
  logic [31:0] norm_weight;
  logic [1:0]  score_mode;

  logic [31:0] bnd [NB];

  logic signed [31:0] r_px, r_py, r_pz, r_w, r_wi;
  logic [31:0] r_en, r_xt, r_xp;

  logic [SLOT_W-1:0] eidx;
  logic [31:0] prev_bound;
  logic [1:0]  axis;
  logic [XW-1:0] ci;
  logic [YW-1:0] cj;
  logic [ZW-1:0] ck;

  logic [79:0] num;
  logic [63:0] den;
  logic [63:0] rem;
  logic [41:0] quo;
  logic [6:0]  cnt;
  logic        div_score;

  logic signed [39:0] sc_reg;
  logic [ADDR_W-1:0]  addr_reg;
  logic               p_scored;
  logic [ADDR_W-1:0]  p_addr;
  logic signed [39:0] p_score;
  logic signed [47:0] p_total;

  logic [47:0] tally [TALLY];
  logic [47:0] mem_rd;
  logic [ADDR_W-1:0] clr_cnt;

  // search
  logic [31:0] cur_bound;
  logic        bin_hit, bin_last;
  assign cur_bound = bnd[SLOT_W'(eidx + 1'b1)];
  assign bin_hit   = (prev_bound <= r_en) && (r_en <= cur_bound);
  assign bin_last  = (eidx == SLOT_W'(ENERGY_BINS - 1));

  // axis select and difference
  logic signed [31:0] sel_pos, sel_low;
  logic [30:0] sel_pitch;
  logic [41:0] sel_n;
  logic signed [32:0] diff;
  always_comb begin
    case (axis)
      cmta_pkg::AXIS_X: begin
        sel_pos = r_px; sel_low = low_x; sel_pitch = pitch_x; sel_n = 42'(MESH_X);
      end
      cmta_pkg::AXIS_Y: begin
        sel_pos = r_py; sel_low = low_y; sel_pitch = pitch_y; sel_n = 42'(MESH_Y);
      end
      default: begin
        sel_pos = r_pz; sel_low = low_z; sel_pitch = pitch_z; sel_n = 42'(MESH_Z);
      end
    endcase
  end
  assign diff = $signed({sel_pos[31], sel_pos}) - $signed({sel_low[31], sel_low});

  logic cell_skip, cell_bad, xs_skip;
  assign cell_skip = diff[32] || (sel_pitch == 31'd0);
  assign cell_bad  = (quo >= sel_n);
  assign xs_skip   = (r_xt == 32'd0) || (norm_weight == 32'd0);

  // divider step
  logic [64:0] rem_sh;
  logic        ge;
  logic [63:0] rem_n;
  logic [42:0] q_sh;
  logic [41:0] quo_n;
  assign rem_sh = {rem, num[79]};
  assign ge     = rem_sh >= {1'b0, den};
  assign rem_n  = ge ? 64'(rem_sh - {1'b0, den}) : rem_sh[63:0];
  assign q_sh   = {quo, ge};
  assign quo_n  = (q_sh >= {1'b0, cmta_pkg::QUOT_CAP}) ? cmta_pkg::QUOT_CAP : q_sh[41:0];

  // shared multiplier
  logic signed [31:0] wsel;
  logic [31:0] mag, mul_a, mul_b;
  logic [63:0] mul_p;
  assign wsel  = (score_mode == cmta_pkg::MODE_IMAG) ? r_wi : r_w;
  assign mag   = wsel[31] ? 32'(-wsel) : wsel;
  assign mul_a = (state == cmta_pkg::S_XCHK) ? r_xt : mag;
  assign mul_b = (state == cmta_pkg::S_XCHK) ? norm_weight :
                 ((score_mode == cmta_pkg::MODE_PARTIAL) ? r_xp : r_xt);
  assign mul_p = mul_a * mul_b;

  // score saturation and address
  logic signed [39:0] sc_calc;
  always_comb begin
    if (wsel[31]) begin
      sc_calc = (quo >= 42'h080_0000_0000) ? cmta_pkg::SCORE_MIN : 40'(-quo[39:0]);
    end else begin
      sc_calc = (quo > 42'h07F_FFFF_FFFF) ? cmta_pkg::SCORE_MAX : $signed(quo[39:0]);
    end
  end

  logic [ADDR_W-1:0] addr_calc;
  assign addr_calc = ADDR_W'(ADDR_W'(eidx) * ADDR_W'(STRIDE_E) + ADDR_W'(ci) * ADDR_W'(STRIDE_X)
                     + ADDR_W'(cj) * ADDR_W'(MESH_Z) + ADDR_W'(ck));

  logic signed [48:0] sum;
  logic signed [47:0] tot_calc;
  assign sum = $signed({mem_rd[47], mem_rd}) + 49'(sc_reg);
  always_comb begin
    if (sum > 49'(cmta_pkg::BIN_MAX)) begin
      tot_calc = cmta_pkg::BIN_MAX;
    end else if (sum < 49'(cmta_pkg::BIN_MIN)) begin
      tot_calc = cmta_pkg::BIN_MIN;
    end else begin
      tot_calc = sum[47:0];
    end
  end

  logic item_take, out_free;
  assign item_take = item_valid && !item_stall;
  assign out_free  = !result_valid || !result_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cmta_pkg::S_CLEAR: if (clr_cnt == ADDR_W'(TALLY - 1)) state_next = cmta_pkg::S_IDLE;
      cmta_pkg::S_IDLE: begin
        if (item_valid) state_next = cmd ? cmta_pkg::S_DONE : cmta_pkg::S_SEARCH;
      end
      cmta_pkg::S_SEARCH: begin
        if (bin_hit) state_next = cmta_pkg::S_CSETUP;
        else if (bin_last) state_next = cmta_pkg::S_DONE;
      end
      cmta_pkg::S_CSETUP: state_next = cell_skip ? cmta_pkg::S_DONE : cmta_pkg::S_DIV;
      cmta_pkg::S_DIV: begin
        if (cnt == 7'd0) state_next = div_score ? cmta_pkg::S_SCORE : cmta_pkg::S_CEND;
      end
      cmta_pkg::S_CEND: begin
        if (cell_bad) state_next = cmta_pkg::S_DONE;
        else if (axis == cmta_pkg::AXIS_Z) state_next = cmta_pkg::S_XCHK;
        else state_next = cmta_pkg::S_CSETUP;
      end
      cmta_pkg::S_XCHK: state_next = xs_skip ? cmta_pkg::S_DONE : cmta_pkg::S_MUL2;
      cmta_pkg::S_MUL2: state_next = cmta_pkg::S_DIV;
      cmta_pkg::S_SCORE: state_next = cmta_pkg::S_UPD;
      cmta_pkg::S_UPD: state_next = cmta_pkg::S_DONE;
      cmta_pkg::S_DONE: if (out_free) state_next = cmta_pkg::S_IDLE;
      default: state_next = cmta_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    item_stall = (state != cmta_pkg::S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cmta_pkg::S_CLEAR;
      clr_cnt <= '0;
      result_valid <= 1'b0;
      low_x <= '0;
      low_y <= '0;
      low_z <= '0;
      pitch_x <= 31'd65536;
      pitch_y <= 31'd65536;
      pitch_z <= 31'd65536;
      norm_weight <= 32'd65536;
      score_mode <= cmta_pkg::MODE_WEIGHT;
      for (int i = 0; i < NB; i++) bnd[i] <= '0;
    end else begin
      state <= state_next;
      if (state == cmta_pkg::S_CLEAR) clr_cnt <= ADDR_W'(clr_cnt + 1'b1);
      if (cfg_write) begin
        case (cfg_index)
          cmta_pkg::REG_LOW_X:   low_x <= cfg_data;
          cmta_pkg::REG_LOW_Y:   low_y <= cfg_data;
          cmta_pkg::REG_LOW_Z:   low_z <= cfg_data;
          cmta_pkg::REG_PITCH_X: pitch_x <= cfg_data[30:0];
          cmta_pkg::REG_PITCH_Y: pitch_y <= cfg_data[30:0];
          cmta_pkg::REG_PITCH_Z: pitch_z <= cfg_data[30:0];
          cmta_pkg::REG_NORM:    norm_weight <= cfg_data;
          cmta_pkg::REG_MODE:    score_mode <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (item_take && cmd && (bound_index < SLOT_W'(NB))) bnd[bound_index] <= energy;
      if (result_valid && !result_stall) result_valid <= 1'b0;
      if (state == cmta_pkg::S_DONE && out_free) result_valid <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      cmta_pkg::S_IDLE: begin
        if (item_take) begin
          r_px <= pos_x;
          r_py <= pos_y;
          r_pz <= pos_z;
          r_en <= energy;
          r_w  <= weight;
          r_wi <= weight_imag;
          r_xt <= xs_total;
          r_xp <= xs_partial;
          eidx <= '0;
          prev_bound <= bnd[0];
          axis <= cmta_pkg::AXIS_X;
          p_scored <= 1'b0;
          p_addr <= '0;
          p_score <= '0;
          p_total <= '0;
        end
      end
      cmta_pkg::S_SEARCH: begin
        if (!bin_hit) begin
          eidx <= SLOT_W'(eidx + 1'b1);
          prev_bound <= cur_bound;
        end
      end
      cmta_pkg::S_CSETUP: begin
        num <= {diff[31:0], 48'd0};
        den <= {33'd0, sel_pitch};
        rem <= '0;
        quo <= '0;
        cnt <= 7'd31;
        div_score <= 1'b0;
      end
      cmta_pkg::S_DIV: begin
        num <= {num[78:0], 1'b0};
        rem <= rem_n;
        quo <= quo_n;
        cnt <= 7'(cnt - 1'b1);
      end
      cmta_pkg::S_CEND: begin
        case (axis)
          cmta_pkg::AXIS_X: ci <= quo[XW-1:0];
          cmta_pkg::AXIS_Y: cj <= quo[YW-1:0];
          default:          ck <= quo[ZW-1:0];
        endcase
        axis <= 2'(axis + 1'b1);
      end
      cmta_pkg::S_XCHK: den <= mul_p;
      cmta_pkg::S_MUL2: begin
        if (score_mode == cmta_pkg::MODE_PARTIAL || score_mode == cmta_pkg::MODE_TOTAL) begin
          num <= {mul_p, 16'd0};
        end else begin
          num <= {16'd0, mag, 32'd0};
        end
        rem <= '0;
        quo <= '0;
        cnt <= 7'd79;
        div_score <= 1'b1;
      end
      cmta_pkg::S_SCORE: begin
        sc_reg <= sc_calc;
        addr_reg <= addr_calc;
      end
      cmta_pkg::S_UPD: begin
        p_scored <= 1'b1;
        p_addr <= addr_reg;
        p_score <= sc_reg;
        p_total <= tot_calc;
      end
      cmta_pkg::S_DONE: begin
        if (out_free) begin
          scored <= p_scored;
          bin_address <= p_addr;
          added_score <= p_score;
          bin_total <= p_total;
        end
      end
      default: ;
    endcase
  end

  // tally memory
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [47:0]       mem_wd;
  always_comb begin
    mem_we = (state == cmta_pkg::S_CLEAR) || (state == cmta_pkg::S_UPD);
    mem_wa = (state == cmta_pkg::S_CLEAR) ? clr_cnt : addr_reg;
    mem_wd = (state == cmta_pkg::S_CLEAR) ? 48'd0 : tot_calc;
  end

  always_ff @(posedge clk) begin
    if (mem_we) tally[mem_wa] <= mem_wd;
    mem_rd <= tally[addr_calc];
  end

  a_idle_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && !scored |-> (added_score == 40'sd0) && (bin_total == 48'sd0)
      && (bin_address == '0))
    else $error("unscored item carries nonzero fields");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("block ready right after taking an item");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == cmta_pkg::S_DONE))
    else $error("result raised outside the finish step");

endmodule
